[sv/udp_socket_demux_table_defines.svh]
// Assertion macros shared by the UDP socket demultiplexing table RTL.
// Depends on nothing; the including module must provide aclk and aresetn.
`ifndef UDP_SOCKET_DEMUX_TABLE_DEFINES_SVH
`define UDP_SOCKET_DEMUX_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define UDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define UDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/udt_pkg.sv]
// Types, codes and constants of the UDP socket demultiplexing table.
// Used by the top level udp_socket_demux_table and by the testbench.
`default_nettype none

package udt_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam logic [15:0] FIRST_FREE_PORT = 16'd1024;
    localparam logic [15:0] HEADER_BYTES = 16'd8;

    typedef enum logic [1:0] {
        KIND_LISTEN     = 2'd0,
        KIND_CONNECT    = 2'd1,
        KIND_DISCONNECT = 2'd2,
        KIND_RECEIVE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_SHORT     = 3'd2,
        STATUS_NO_MATCH  = 3'd3,
        STATUS_BAD_INDEX = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_SCAN_RD,
        ST_SCAN_CMP
    } state_t;

    typedef struct packed {
        logic        listening;
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic [15:0] local_port;
    } entry_t;

endpackage

`default_nettype wire

[sv/udt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the endpoint table of udp_socket_demux_table.
`default_nettype none

module udt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/udp_socket_demux_table.sv]
// Top level of the UDP socket demultiplexing table: sequencer, counters, result register.
// Depends on udt_pkg, udt_ram and udp_socket_demux_table_defines.svh.
//
// One request enters on the s_ channel: s_tuser carries the operation kind and s_tdata
// its operands. Exactly one result leaves on the m_ channel for every request, with the
// status on m_tuser. The own address register is written through cfg_we and cfg_wdata;
// the user must write it only while the block is idle, which the block does not enforce.
// The endpoint table lives in a single RAM with one write and one registered read port,
// and that port sets the order of work: listen, connect, a full table, a bad index and a
// short datagram are settled in ST_EXEC, from where the result is registered; disconnect
// goes through ST_EXEC, ST_MOVE_RD and ST_MOVE_WR, since the last entry is read and then
// written into the freed slot. A receive walks the table in order, reading each entry
// in ST_SCAN_RD and comparing it in ST_SCAN_CMP, up to the first match or the last
// entry. The block takes one request at a time; s_tready is high only when it is idle.
// The result is held in an output register, so a stalled receiver only blocks a request
// that is ready to finish. Reset empties the table, sets the next connect port to 1024,
// clears the own address and drops m_tvalid; no clearing pass is needed.
`default_nettype none

`include "udp_socket_demux_table_defines.svh"

module udp_socket_demux_table #(
    parameter int MAX_ENTRIES = udt_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // Fields from bit 0: dst_port[15:0], src_port[31:16], dst_ip[63:32], src_ip[95:64],
    // datagram_length[111:96], entry_to_remove[117:112], zero padding[119:118].
    input  wire logic [119:0] s_tdata,
    // Fields from bit 0: kind[1:0].
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // Fields from bit 0: entry_index[5:0], assigned_port[21:6], moved_from[27:22],
    // bound_now[28], zero padding[31:29].
    output logic [31:0]       m_tdata,
    // Fields from bit 0: status[2:0].
    output logic [2:0]        m_tuser
);

    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W   = (CNT_W > 6) ? CNT_W : 6;
    localparam int ENTRY_W = $bits(udt_pkg::entry_t);

    udt_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      port_reg, port_next;
    logic [31:0]      own_ip_reg;
    logic [IDX_W-1:0] scan_reg, scan_next;

    udt_pkg::kind_t   kind_reg;
    logic [15:0]      dport_reg;
    logic [15:0]      sport_reg;
    logic [31:0]      dip_reg;
    logic [31:0]      sip_reg;
    logic [15:0]      len_reg;
    logic [5:0]       rem_reg;

    logic              m_valid_reg;
    udt_pkg::status_t  status_reg;
    logic [5:0]        idx_reg;
    logic [15:0]       aport_reg;
    logic [5:0]        moved_reg;
    logic              bound_reg;

    logic              emit;
    udt_pkg::status_t  res_status;
    logic [5:0]        res_idx;
    logic [15:0]       res_aport;
    logic [5:0]        res_moved;
    logic              res_bound;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    udt_pkg::entry_t   mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    udt_pkg::entry_t   rd_entry;

    logic              s_accept;
    logic              can_emit;
    logic              table_full;
    logic              rem_valid;
    logic [IDX_W-1:0]  last_idx;
    logic              scan_last;
    logic              addr_hit;
    logic              pair_hit;
    logic              hit;

    udt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_table (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign rd_entry   = udt_pkg::entry_t'(mem_rdata);
    assign s_tready   = (state_reg == udt_pkg::ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign can_emit   = !m_valid_reg || m_tready;
    assign table_full = (count_reg == CNT_W'(MAX_ENTRIES));
    assign rem_valid  = (CMP_W'(rem_reg) < CMP_W'(count_reg));
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign scan_last  = (CNT_W'(scan_reg) == count_reg - CNT_W'(1));

    // The shared compare unit looks at one table entry per visit.
    assign addr_hit = (rd_entry.local_port == dport_reg) && (rd_entry.local_addr == dip_reg);
    assign pair_hit = (rd_entry.remote_port == sport_reg) && (rd_entry.remote_addr == sip_reg);
    assign hit      = addr_hit && (rd_entry.listening || pair_hit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= udt_pkg::ST_IDLE;
            count_reg   <= '0;
            port_reg    <= udt_pkg::FIRST_FREE_PORT;
            own_ip_reg  <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            port_reg  <= port_next;
            scan_reg  <= scan_next;
            if (cfg_we) begin
                own_ip_reg <= cfg_wdata;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg  <= udt_pkg::kind_t'(s_tuser);
            dport_reg <= s_tdata[15:0];
            sport_reg <= s_tdata[31:16];
            dip_reg   <= s_tdata[63:32];
            sip_reg   <= s_tdata[95:64];
            len_reg   <= s_tdata[111:96];
            rem_reg   <= s_tdata[117:112];
        end
        if (emit) begin
            status_reg <= res_status;
            idx_reg    <= res_idx;
            aport_reg  <= res_aport;
            moved_reg  <= res_moved;
            bound_reg  <= res_bound;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        port_next  = port_reg;
        scan_next  = scan_reg;
        emit       = 1'b0;
        res_status = udt_pkg::STATUS_OK;
        res_idx    = '0;
        res_aport  = '0;
        res_moved  = '0;
        res_bound  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        case (state_reg)
            udt_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = udt_pkg::ST_EXEC;
                end
            end
            udt_pkg::ST_EXEC: begin
                case (kind_reg)
                    udt_pkg::KIND_LISTEN, udt_pkg::KIND_CONNECT: begin
                        if (can_emit) begin
                            emit       = 1'b1;
                            state_next = udt_pkg::ST_IDLE;
                            if (table_full) begin
                                res_status = udt_pkg::STATUS_FULL;
                            end else begin
                                mem_we                = 1'b1;
                                mem_waddr             = IDX_W'(count_reg);
                                mem_wdata.local_addr  = own_ip_reg;
                                res_idx               = 6'(count_reg);
                                count_next            = count_reg + CNT_W'(1);
                                if (kind_reg == udt_pkg::KIND_LISTEN) begin
                                    mem_wdata.local_port = dport_reg;
                                    mem_wdata.listening  = 1'b1;
                                end else begin
                                    mem_wdata.local_port  = port_reg;
                                    mem_wdata.remote_port = sport_reg;
                                    mem_wdata.remote_addr = sip_reg;
                                    res_aport             = port_reg;
                                    port_next             = port_reg + 16'd1;
                                end
                            end
                        end
                    end
                    udt_pkg::KIND_DISCONNECT: begin
                        if (rem_valid) begin
                            state_next = udt_pkg::ST_MOVE_RD;
                        end else if (can_emit) begin
                            emit       = 1'b1;
                            res_status = udt_pkg::STATUS_BAD_INDEX;
                            state_next = udt_pkg::ST_IDLE;
                        end
                    end
                    udt_pkg::KIND_RECEIVE: begin
                        if (len_reg < udt_pkg::HEADER_BYTES) begin
                            if (can_emit) begin
                                emit       = 1'b1;
                                res_status = udt_pkg::STATUS_SHORT;
                                state_next = udt_pkg::ST_IDLE;
                            end
                        end else if (count_reg == '0) begin
                            if (can_emit) begin
                                emit       = 1'b1;
                                res_status = udt_pkg::STATUS_NO_MATCH;
                                state_next = udt_pkg::ST_IDLE;
                            end
                        end else begin
                            scan_next  = '0;
                            state_next = udt_pkg::ST_SCAN_RD;
                        end
                    end
                    default: begin
                        state_next = udt_pkg::ST_IDLE;
                    end
                endcase
            end
            udt_pkg::ST_MOVE_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = last_idx;
                state_next = udt_pkg::ST_MOVE_WR;
            end
            udt_pkg::ST_MOVE_WR: begin
                if (can_emit) begin
                    mem_we     = 1'b1;
                    mem_waddr  = IDX_W'(rem_reg);
                    mem_wdata  = rd_entry;
                    count_next = count_reg - CNT_W'(1);
                    emit       = 1'b1;
                    res_idx    = rem_reg;
                    res_moved  = 6'(last_idx);
                    state_next = udt_pkg::ST_IDLE;
                end
            end
            udt_pkg::ST_SCAN_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = scan_reg;
                state_next = udt_pkg::ST_SCAN_CMP;
            end
            udt_pkg::ST_SCAN_CMP: begin
                if (hit) begin
                    if (can_emit) begin
                        emit       = 1'b1;
                        res_idx    = 6'(scan_reg);
                        res_bound  = rd_entry.listening;
                        state_next = udt_pkg::ST_IDLE;
                        if (rd_entry.listening) begin
                            mem_we                = 1'b1;
                            mem_waddr             = scan_reg;
                            mem_wdata             = rd_entry;
                            mem_wdata.listening   = 1'b0;
                            mem_wdata.remote_port = sport_reg;
                            mem_wdata.remote_addr = sip_reg;
                        end
                    end
                end else if (scan_last) begin
                    if (can_emit) begin
                        emit       = 1'b1;
                        res_status = udt_pkg::STATUS_NO_MATCH;
                        state_next = udt_pkg::ST_IDLE;
                    end
                end else begin
                    scan_next  = scan_reg + IDX_W'(1);
                    state_next = udt_pkg::ST_SCAN_RD;
                end
            end
            default: begin
                state_next = udt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, bound_reg, moved_reg, aport_reg, idx_reg};

    `UDT_ASSERT_NOW(a_count_bounded, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES), "entry count exceeds table size")
    `UDT_ASSERT_NEXT(a_full_keeps_count, emit && res_status == udt_pkg::STATUS_FULL, $stable(count_reg) && $stable(port_reg), "full table was modified")
    `UDT_ASSERT_NOW(a_bound_is_ok, m_valid_reg && bound_reg, status_reg == udt_pkg::STATUS_OK, "binding reported without a match")
    `UDT_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_tready, "request accepted while another is in progress")

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for the UDP socket demultiplexing table, udp_socket_demux_table.
// It predicts every reply from its own copy of the endpoint table and compares the replies
// field by field; it depends on udt_pkg and on the top level only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = udt_pkg::MAX_ENTRIES_DEF;
    localparam int REMOTE_POOL = 6;
    localparam int PORT_PAIRS = 16;

    localparam udt_pkg::kind_t OP_LISTEN     = udt_pkg::KIND_LISTEN;
    localparam udt_pkg::kind_t OP_CONNECT    = udt_pkg::KIND_CONNECT;
    localparam udt_pkg::kind_t OP_DISCONNECT = udt_pkg::KIND_DISCONNECT;
    localparam udt_pkg::kind_t OP_RECEIVE    = udt_pkg::KIND_RECEIVE;

    typedef struct packed {
        udt_pkg::kind_t kind;
        logic [15:0]    dst_port;
        logic [15:0]    src_port;
        logic [31:0]    dst_ip;
        logic [31:0]    src_ip;
        logic [15:0]    dgram_len;
        logic [5:0]     slot;
    } sock_req_t;

    typedef struct packed {
        udt_pkg::status_t status;
        logic [5:0]       entry;
        logic [15:0]      port;
        logic [5:0]       moved;
        logic             bound;
    } sock_reply_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [2:0]   m_tuser;

    udp_socket_demux_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    sock_req_t   request_backlog [$];
    sock_reply_t reply_queue [$];
    sock_req_t   on_offer;
    bit          req_taken = 1'b0;
    bit          res_taken = 1'b0;
    bit          idle_on = 1'b1;
    int          n_sent = 0;
    int          n_done = 0;
    int          send_gap = 0;
    int          recv_wait = 0;
    int          bad_replies = 0;
    int          status_tally [5] = '{default: 0};
    int          binds = 0;
    bit          port_wrapped = 1'b0;

    logic [15:0] tbl_lport [TABLE_DEPTH];
    logic [15:0] tbl_rport [TABLE_DEPTH];
    logic [31:0] tbl_raddr [TABLE_DEPTH];
    logic [31:0] tbl_laddr [TABLE_DEPTH];
    logic        tbl_listen [TABLE_DEPTH];
    int          tbl_count = 0;
    logic [15:0] tbl_next_port = udt_pkg::FIRST_FREE_PORT;
    logic [31:0] tbl_own_ip = '0;

    logic [31:0] gen_own_ip = '0;
    logic [31:0] prev_own_ip = '0;
    logic [15:0] approx_next_port = udt_pkg::FIRST_FREE_PORT;
    logic [15:0] listen_ports [4] = '{16'd80, 16'd53, 16'h0000, 16'hFFFF};
    logic [15:0] pool_rport [REMOTE_POOL];
    logic [31:0] pool_raddr [REMOTE_POOL];

    function automatic sock_reply_t demux_step(input sock_req_t q);
        sock_reply_t r;
        int          last;
        bit          found;
        r.status = udt_pkg::STATUS_OK;
        r.entry = '0;
        r.port = '0;
        r.moved = '0;
        r.bound = 1'b0;
        case (q.kind)
            OP_LISTEN, OP_CONNECT: begin
                if (tbl_count >= TABLE_DEPTH) begin
                    r.status = udt_pkg::STATUS_FULL;
                end else begin
                    r.entry = tbl_count[5:0];
                    tbl_laddr[tbl_count] = tbl_own_ip;
                    if (q.kind == OP_LISTEN) begin
                        tbl_lport[tbl_count] = q.dst_port;
                        tbl_rport[tbl_count] = '0;
                        tbl_raddr[tbl_count] = '0;
                        tbl_listen[tbl_count] = 1'b1;
                    end else begin
                        r.port = tbl_next_port;
                        if (tbl_next_port == 16'hFFFF) port_wrapped = 1'b1;
                        tbl_next_port = tbl_next_port + 16'd1;
                        tbl_lport[tbl_count] = r.port;
                        tbl_rport[tbl_count] = q.src_port;
                        tbl_raddr[tbl_count] = q.src_ip;
                        tbl_listen[tbl_count] = 1'b0;
                    end
                    tbl_count++;
                end
            end
            OP_DISCONNECT: begin
                if (int'(q.slot) >= tbl_count) begin
                    r.status = udt_pkg::STATUS_BAD_INDEX;
                end else begin
                    last = tbl_count - 1;
                    tbl_lport[q.slot] = tbl_lport[last];
                    tbl_rport[q.slot] = tbl_rport[last];
                    tbl_raddr[q.slot] = tbl_raddr[last];
                    tbl_laddr[q.slot] = tbl_laddr[last];
                    tbl_listen[q.slot] = tbl_listen[last];
                    tbl_count = last;
                    r.entry = q.slot;
                    r.moved = last[5:0];
                end
            end
            default: begin
                if (q.dgram_len < udt_pkg::HEADER_BYTES) begin
                    r.status = udt_pkg::STATUS_SHORT;
                end else begin
                    r.status = udt_pkg::STATUS_NO_MATCH;
                    found = 1'b0;
                    for (int i = 0; i < tbl_count; i++) begin
                        if (!found && tbl_lport[i] == q.dst_port &&
                            tbl_laddr[i] == q.dst_ip) begin
                            if (tbl_listen[i]) begin
                                tbl_listen[i] = 1'b0;
                                tbl_rport[i] = q.src_port;
                                tbl_raddr[i] = q.src_ip;
                                r.bound = 1'b1;
                                found = 1'b1;
                            end else if (tbl_rport[i] == q.src_port &&
                                         tbl_raddr[i] == q.src_ip) begin
                                found = 1'b1;
                            end
                            if (found) begin
                                r.status = udt_pkg::STATUS_OK;
                                r.entry = i[5:0];
                            end
                        end
                    end
                end
            end
        endcase
        status_tally[int'(r.status)]++;
        if (r.bound) binds++;
        return r;
    endfunction

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, 16)) : 0;
    endfunction

    function automatic sock_req_t random_req(input bit noise, input bit filling);
        sock_req_t   q;
        int unsigned pick;
        int unsigned rp;
        q.kind = udt_pkg::kind_t'($urandom_range(0, 3));
        q.dst_port = 16'($urandom);
        q.src_port = 16'($urandom);
        q.dst_ip = $urandom;
        q.src_ip = $urandom;
        q.dgram_len = 16'($urandom);
        q.slot = 6'($urandom);
        if (noise) return q;
        pick = $urandom_range(0, 99);
        if (filling) begin
            q.kind = (pick < 45) ? OP_LISTEN : (pick < 90) ? OP_CONNECT : OP_RECEIVE;
        end else begin
            q.kind = (pick < 12) ? OP_LISTEN : (pick < 25) ? OP_CONNECT :
                     (pick < 50) ? OP_DISCONNECT : OP_RECEIVE;
        end
        rp = $urandom_range(0, REMOTE_POOL - 1);
        if ($urandom_range(0, 99) < 80) begin
            q.src_port = pool_rport[rp];
            q.src_ip = pool_raddr[rp];
        end
        case (q.kind)
            OP_LISTEN: begin
                if ($urandom_range(0, 3) != 0) q.dst_port = listen_ports[$urandom_range(0, 3)];
            end
            OP_DISCONNECT: begin
                q.slot = 6'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 15) :
                                                          $urandom_range(0, 63));
            end
            OP_RECEIVE: begin
                pick = $urandom_range(0, 99);
                if (pick < 45) q.dst_port = listen_ports[$urandom_range(0, 3)];
                else if (pick < 85) q.dst_port = approx_next_port - 16'($urandom_range(1, 64));
                pick = $urandom_range(0, 99);
                if (pick < 80) q.dst_ip = gen_own_ip;
                else if (pick < 90) q.dst_ip = prev_own_ip;
                q.dgram_len = 16'(($urandom_range(0, 99) < 6) ? $urandom_range(0, 7) :
                                                                $urandom_range(8, 65535));
            end
            default: ;
        endcase
        return q;
    endfunction

    task automatic push_item(input sock_req_t q);
        if (q.kind == OP_CONNECT) approx_next_port = approx_next_port + 16'd1;
        request_backlog.push_back(q);
    endtask

    task automatic push_req(input udt_pkg::kind_t k, input logic [15:0] dport,
                            input logic [15:0] sport, input logic [31:0] dip,
                            input logic [31:0] sip, input logic [15:0] len,
                            input logic [5:0] slot);
        sock_req_t q;
        q.kind = k;
        q.dst_port = dport;
        q.src_port = sport;
        q.dst_ip = dip;
        q.src_ip = sip;
        q.dgram_len = len;
        q.slot = slot;
        push_item(q);
    endtask

    task automatic wait_idle();
        while (request_backlog.size() != 0 || n_done < n_sent) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_own_ip(input logic [31:0] value);
        wait_idle();
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        prev_own_ip = gen_own_ip;
        gen_own_ip = value;
    endtask

    always @(negedge aclk) begin
        if (!(s_tvalid && !req_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
                on_offer = request_backlog.pop_front();
                n_sent++;
                s_tdata <= {2'b00, on_offer.slot, on_offer.dgram_len, on_offer.src_ip,
                            on_offer.dst_ip, on_offer.src_port, on_offer.dst_port};
                s_tuser <= on_offer.kind;
                s_tvalid <= 1'b1;
                send_gap = draw_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // The receiver holds off once for a long stretch so that a finished request blocks
    // the input while the sender keeps offering.
    always @(negedge aclk) begin
        if (res_taken) recv_wait = (n_done == 200) ? 400 : draw_gap();
        if (recv_wait > 0) begin
            recv_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sock_reply_t seen;
        sock_reply_t want;
        req_taken = aresetn && s_tvalid && s_tready;
        res_taken = aresetn && m_tvalid && m_tready;
        if (res_taken) begin
            n_done++;
            seen.status = udt_pkg::status_t'(m_tuser);
            seen.entry = m_tdata[5:0];
            seen.port = m_tdata[21:6];
            seen.moved = m_tdata[27:22];
            seen.bound = m_tdata[28];
            if (reply_queue.size() == 0) begin
                bad_replies++;
                if (bad_replies <= 10)
                    $display("Reply %0d arrived with no request waiting.", n_done);
            end else begin
                want = reply_queue.pop_front();
                if (seen !== want) begin
                    bad_replies++;
                    if (bad_replies <= 10) begin
                        $display("Reply %0d: expected status %0d entry %0d port %0d moved %0d bound %0d,",
                                 n_done, want.status, want.entry, want.port, want.moved,
                                 want.bound);
                        $display("    got status %0d entry %0d port %0d moved %0d bound %0d.",
                                 seen.status, seen.entry, seen.port, seen.moved, seen.bound);
                    end
                end
            end
        end
        if (aresetn && cfg_we) tbl_own_ip = cfg_wdata;
        if (req_taken) reply_queue.push_back(demux_step(on_offer));
    end

    initial begin
        #2_000_000;
        $display("FAIL udp_socket_demux_table");
        $finish;
    end

    initial begin
        pool_rport[0] = 16'd1234;
        pool_raddr[0] = 32'h0A00_0001;
        pool_rport[1] = 16'd4321;
        pool_raddr[1] = 32'h0A00_0002;
        pool_rport[2] = 16'h0000;
        pool_raddr[2] = 32'h0000_0000;
        pool_rport[3] = 16'hFFFF;
        pool_raddr[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < REMOTE_POOL; i++) begin
            pool_rport[i] = 16'($urandom);
            pool_raddr[i] = $urandom;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_own_ip(32'hFFFF_FFFF);
        push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        push_req(OP_RECEIVE, 16'hFFFF, 16'd1234, 32'hFFFF_FFFF, 32'h0A00_0001, 16'd7, 6'd0);
        push_req(OP_RECEIVE, 16'hFFFF, 16'd1234, 32'hFFFF_FFFF, 32'h0A00_0001, 16'd0, 6'd0);
        push_req(OP_RECEIVE, 16'hFFFF, 16'd1234, 32'hFFFF_FFFF, 32'h0A00_0001, 16'd8, 6'd0);
        push_req(OP_LISTEN, 16'hFFFF, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        push_req(OP_LISTEN, 16'h0000, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        push_req(OP_CONNECT, 16'd0, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 16'd0, 6'd0);
        push_req(OP_CONNECT, 16'd0, 16'h0000, 32'd0, 32'h0000_0000, 16'd0, 6'd0);
        push_req(OP_RECEIVE, 16'hFFFF, 16'd1234, 32'hFFFF_FFFF, 32'h0A00_0001, 16'hFFFF, 6'd0);
        push_req(OP_RECEIVE, 16'hFFFF, 16'd1234, 32'hFFFF_FFFF, 32'h0A00_0001, 16'd8, 6'd0);
        push_req(OP_RECEIVE, 16'hFFFF, 16'd4321, 32'hFFFF_FFFF, 32'h0A00_0002, 16'd8, 6'd0);
        push_req(OP_RECEIVE, 16'd1024, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd8, 6'd0);
        push_req(OP_RECEIVE, 16'd1024, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF, 16'd8, 6'd0);
        push_req(OP_RECEIVE, 16'd0, 16'd0, 32'hFFFF_FFFF, 32'd0, 16'd100, 6'd0);
        push_req(OP_RECEIVE, 16'd1025, 16'd0, 32'hFFFF_FFFF, 32'd0, 16'd8, 6'd0);
        push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd63);
        push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd4);
        push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd2);
        push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        push_req(OP_LISTEN, 16'd80, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        push_req(OP_LISTEN, 16'd80, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        push_req(OP_RECEIVE, 16'd80, 16'd1234, 32'hFFFF_FFFF, 32'h0A00_0001, 16'd20, 6'd0);
        push_req(OP_RECEIVE, 16'd80, 16'd4321, 32'hFFFF_FFFF, 32'h0A00_0002, 16'd20, 6'd0);
        push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);

        // Open and close connections back to back so that the port counter keeps advancing.
        wait_idle();
        idle_on = 1'b0;
        for (int i = 0; i < PORT_PAIRS; i++) begin
            push_req(OP_CONNECT, 16'd0, 16'($urandom), 32'd0, $urandom, 16'd0, 6'd0);
            push_req(OP_DISCONNECT, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 6'd0);
        end

        write_own_ip(32'h0000_0000);
        idle_on = 1'b1;
        for (int i = 0; i < 80; i++) push_item(random_req(1'b0, 1'b1));

        write_own_ip($urandom);
        for (int i = 0; i < 120; i++) push_item(random_req($urandom_range(0, 99) < 15, 1'b0));

        write_own_ip(32'h8000_0001);
        idle_on = 1'b0;
        for (int i = 0; i < 120; i++) push_item(random_req($urandom_range(0, 99) < 15, 1'b0));

        write_own_ip($urandom);
        idle_on = 1'b1;
        for (int i = 0; i < 120; i++) push_item(random_req($urandom_range(0, 99) < 15, 1'b0));

        wait_idle();
        repeat (20) @(negedge aclk);
        $display("Checked %0d replies: %0d ok, %0d table full, %0d too short,",
                 n_done, status_tally[int'(udt_pkg::STATUS_OK)],
                 status_tally[int'(udt_pkg::STATUS_FULL)],
                 status_tally[int'(udt_pkg::STATUS_SHORT)]);
        $display("%0d no match, %0d bad index.",
                 status_tally[int'(udt_pkg::STATUS_NO_MATCH)],
                 status_tally[int'(udt_pkg::STATUS_BAD_INDEX)]);
        $display("Listening entries bound: %0d; connect port counter wrapped: %0s; mismatches: %0d.",
                 binds, port_wrapped ? "yes" : "no", bad_replies);
        if (bad_replies == 0 && reply_queue.size() == 0) begin
            $display("PASS udp_socket_demux_table");
        end else begin
            $display("FAIL udp_socket_demux_table");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/udt_pkg.sv
sv/udt_ram.sv
sv/udp_socket_demux_table.sv
tb/tb.sv
